### design/wtag_pkg.sv
// Shared types and constants for the wall texel address generator.
`timescale 1ns / 1ps

package wtag_pkg;

  localparam int COORD_FRAC_BITS   = 8;
  localparam int SCREEN_COORD_BITS = 12;

  localparam int HIT_W     = 24;
  localparam int HIT_INT_W = HIT_W - COORD_FRAC_BITS;
  localparam int SCR_W     = SCREEN_COORD_BITS;
  localparam int TILE_W    = 11;
  localparam int TEX_W     = 13;
  localparam int PITCH_W   = 16;
  localparam int PBYTES_W  = 4;
  localparam int WTOP_W    = 16;
  localparam int STRIP_W   = 16;
  localparam int ADDR_W    = 32;
  localparam int DIFF_W    = WTOP_W + 1;

  // column path: offset = {tile remainder, fraction}, divisor = tile << frac
  localparam int OFS_W    = TILE_W + COORD_FRAC_BITS;
  localparam int NUMC_W   = OFS_W + TEX_W;
  // row path: numerator = row offset * tex_height
  localparam int NUMR_W   = STRIP_W + TEX_W;
  localparam int PROD_R_W = SCR_W + PITCH_W;
  localparam int PROD_C_W = SCR_W + PBYTES_W;

  localparam int MOD_STEPS = HIT_INT_W;
  localparam int DIV_STEPS = TEX_W;

  localparam logic [TEX_W-1:0] FIELD_MAX = TEX_W'((1 << SCR_W) - 1);

  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_SIZE   = 3'd0,
    CFG_TEX_WIDTH   = 3'd1,
    CFG_TEX_HEIGHT  = 3'd2,
    CFG_ROW_PITCH   = 3'd3,
    CFG_PIXEL_BYTES = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TILE_W-1:0]   tile_size;
    logic [TEX_W-1:0]    tex_width;
    logic [TEX_W-1:0]    tex_height;
    logic [PITCH_W-1:0]  row_pitch;
    logic [PBYTES_W-1:0] pixel_bytes;
  } cfg_t;

  // classified item, front to back
  typedef struct packed {
    logic [HIT_INT_W-1:0]       hit_int;
    logic [COORD_FRAC_BITS-1:0] hit_frac;
    logic                       row_le0;
    logic [STRIP_W-1:0]         diff;
    logic [STRIP_W-1:0]         div_r;
    logic [ADDR_W-1:0]          base;
    logic [SCR_W-1:0]           scol;
    logic [SCR_W-1:0]           srow;
    logic                       last;
  } ent_t;

  typedef struct packed {
    ent_t                ent;
    logic [TILE_W-1:0]   mod_r;
    logic [NUMC_W-1:0]   num_c;
    logic [NUMR_W-1:0]   num_r;
    logic [OFS_W-1:0]    rem_c;
    logic [STRIP_W-1:0]  rem_r;
    logic [TEX_W-1:0]    q_c;
    logic [TEX_W-1:0]    q_r;
    logic                ovf_r;
    logic [SCR_W-1:0]    tcol;
    logic [SCR_W-1:0]    trow;
    logic [PROD_R_W-1:0] prod_r;
    logic [PROD_C_W-1:0] prod_c;
  } back_t;

  typedef struct packed {
    logic [SCR_W-1:0]  texel_col;
    logic [SCR_W-1:0]  texel_row;
    logic [ADDR_W-1:0] texel_address;
    logic [SCR_W-1:0]  out_column;
    logic [SCR_W-1:0]  out_row;
    logic              strip_last;
  } res_t;

endpackage

### design/wtag_front.sv
// Front end: takes items, selects the hit coordinate and classifies the row offset.
`timescale 1ns / 1ps

module wtag_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           hold_i,
  output logic                           busy,
  input  logic [wtag_pkg::HIT_W-1:0]     hit_x_i,
  input  logic [wtag_pkg::HIT_W-1:0]     hit_y_i,
  input  logic                           vertical_hit_i,
  input  logic [wtag_pkg::SCR_W-1:0]     screen_row_i,
  input  logic signed [wtag_pkg::WTOP_W-1:0] wall_top_i,
  input  logic [wtag_pkg::STRIP_W-1:0]   strip_height_i,
  input  logic [wtag_pkg::SCR_W-1:0]     screen_column_i,
  input  logic                           column_end_i,
  input  logic [wtag_pkg::ADDR_W-1:0]    texture_base_i,
  output logic                           push_o,
  output wtag_pkg::ent_t                 ent_o
);
  import wtag_pkg::*;

  logic              acc;
  logic [HIT_W-1:0]  hit;
  logic [DIFF_W-1:0] dsum;
  ent_t              ent_d, ent_q;
  logic              vld_q;

  assign busy = hold_i;
  assign acc  = start & ~hold_i;

  always_comb begin
    hit  = vertical_hit_i ? hit_y_i : hit_x_i;
    // two's complement over one extra bit, sign bit is exact
    dsum = DIFF_W'({{(DIFF_W-SCR_W){1'b0}}, screen_row_i})
         - DIFF_W'({wall_top_i[WTOP_W-1], wall_top_i});
    ent_d          = '0;
    ent_d.hit_int  = hit[HIT_W-1:COORD_FRAC_BITS];
    ent_d.hit_frac = hit[COORD_FRAC_BITS-1:0];
    ent_d.row_le0  = dsum[DIFF_W-1] | (dsum == '0);
    ent_d.diff     = dsum[STRIP_W-1:0];
    ent_d.div_r    = (strip_height_i == '0) ? STRIP_W'(1) : strip_height_i;
    ent_d.base     = texture_base_i;
    ent_d.scol     = screen_column_i;
    ent_d.srow     = screen_row_i;
    ent_d.last     = column_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ent_q <= ent_d;
    end
  end

  assign push_o = vld_q;
  assign ent_o  = ent_q;

endmodule

### design/wtag_fifo.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps

module wtag_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wtag_pkg::ent_t data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output wtag_pkg::ent_t data_o,
  output logic           afull_o
);
  import wtag_pkg::*;

  ent_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i & valid_o;
  assign data_o  = mem_q[rd_q];
  // one slot kept spare for the item sitting in the front register
  assign afull_o = (cnt_q >= FIFO_CNT_W'(FIFO_DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + FIFO_PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + FIFO_CNT_W'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### design/wtag_back.sv
// Back end: tile modulo, scaling dividers, clamps and texel address pipeline.
`timescale 1ns / 1ps

module wtag_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  wtag_pkg::ent_t in_ent_i,
  input  wtag_pkg::cfg_t cfg_i,
  output logic           res_valid_o,
  output wtag_pkg::res_t res_o
);
  import wtag_pkg::*;

  back_t mod_q   [MOD_STEPS];
  logic  mod_v_q [MOD_STEPS];
  back_t div_q   [DIV_STEPS];
  logic  div_v_q [DIV_STEPS];
  back_t mul_q, mul_d, clp_q, clp_d, mp_q, mp_d;
  logic  mul_v_q, clp_v_q, mp_v_q, res_v_q;
  res_t  res_q, res_d;

  logic [OFS_W-1:0] dvs_c;
  logic [TEX_W-1:0] w_lim, h_lim;

  assign dvs_c = {cfg_i.tile_size, {COORD_FRAC_BITS{1'b0}}};
  assign w_lim = cfg_i.tex_width - TEX_W'(1);
  assign h_lim = cfg_i.tex_height - TEX_W'(1);

  // integer part of hit mod tile_size, one bit per stage
  for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
    back_t           src, nxt;
    logic            src_v;
    logic [TILE_W:0] t;

    if (k == 0) begin : g_first
      always_comb begin
        src     = '0;
        src.ent = in_ent_i;
      end
      assign src_v = in_valid_i;
    end else begin : g_next
      assign src   = mod_q[k-1];
      assign src_v = mod_v_q[k-1];
    end

    always_comb begin
      nxt = src;
      t   = {src.mod_r, src.ent.hit_int[MOD_STEPS-1-k]};
      if (t >= {1'b0, cfg_i.tile_size}) begin
        nxt.mod_r = TILE_W'(t - {1'b0, cfg_i.tile_size});
      end else begin
        nxt.mod_r = t[TILE_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mod_v_q[k] <= 1'b0;
      end else begin
        mod_v_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      mod_q[k] <= nxt;
    end
  end

  // numerators for both scalings
  always_comb begin
    mul_d       = mod_q[MOD_STEPS-1];
    mul_d.num_c = NUMC_W'({mod_q[MOD_STEPS-1].mod_r, mod_q[MOD_STEPS-1].ent.hit_frac})
                * NUMC_W'(cfg_i.tex_width);
    mul_d.num_r = NUMR_W'(mod_q[MOD_STEPS-1].ent.diff) * NUMR_W'(cfg_i.tex_height);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else begin
      mul_v_q <= mod_v_q[MOD_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
  end

  // restoring dividers, one quotient bit of column and row per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    back_t              src, nxt;
    logic               src_v;
    logic [OFS_W:0]     tc;
    logic [STRIP_W:0]   tr;

    if (k == 0) begin : g_first
      always_comb begin
        src       = mul_q;
        // column quotient is known to stay below tex_width, so no overflow
        src.rem_c = mul_q.num_c[NUMC_W-1 -: OFS_W];
        src.rem_r = mul_q.num_r[NUMR_W-1 -: STRIP_W];
        src.ovf_r = (mul_q.num_r[NUMR_W-1 -: STRIP_W] >= mul_q.ent.div_r);
      end
      assign src_v = mul_v_q;
    end else begin : g_next
      assign src   = div_q[k-1];
      assign src_v = div_v_q[k-1];
    end

    always_comb begin
      nxt = src;
      tc  = {src.rem_c, src.num_c[DIV_STEPS-1-k]};
      tr  = {src.rem_r, src.num_r[DIV_STEPS-1-k]};
      if (tc >= {1'b0, dvs_c}) begin
        nxt.rem_c                = OFS_W'(tc - {1'b0, dvs_c});
        nxt.q_c[DIV_STEPS-1-k]   = 1'b1;
      end else begin
        nxt.rem_c = tc[OFS_W-1:0];
      end
      if (tr >= {1'b0, src.ent.div_r}) begin
        nxt.rem_r                = STRIP_W'(tr - {1'b0, src.ent.div_r});
        nxt.q_r[DIV_STEPS-1-k]   = 1'b1;
      end else begin
        nxt.rem_r = tr[STRIP_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k] <= 1'b0;
      end else begin
        div_v_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[k] <= nxt;
    end
  end

  // clamp to texture size and to the field range; zero when a size is zero or the row offset is not positive
  always_comb begin
    logic [TEX_W-1:0] vc;
    logic [TEX_W-1:0] vr;
    clp_d = div_q[DIV_STEPS-1];
    vc    = div_q[DIV_STEPS-1].q_c;
    vr    = div_q[DIV_STEPS-1].ovf_r ? '1 : div_q[DIV_STEPS-1].q_r;
    if (vc > w_lim) begin
      vc = w_lim;
    end
    if (vc > FIELD_MAX) begin
      vc = FIELD_MAX;
    end
    if (vr > h_lim) begin
      vr = h_lim;
    end
    if (vr > FIELD_MAX) begin
      vr = FIELD_MAX;
    end
    if (cfg_i.tile_size == '0 || cfg_i.tex_width == '0) begin
      clp_d.tcol = '0;
    end else begin
      clp_d.tcol = vc[SCR_W-1:0];
    end
    if (div_q[DIV_STEPS-1].ent.row_le0 || cfg_i.tex_height == '0) begin
      clp_d.trow = '0;
    end else begin
      clp_d.trow = vr[SCR_W-1:0];
    end
  end

  always_comb begin
    mp_d        = clp_q;
    mp_d.prod_r = PROD_R_W'(clp_q.trow) * PROD_R_W'(cfg_i.row_pitch);
    mp_d.prod_c = PROD_C_W'(clp_q.tcol) * PROD_C_W'(cfg_i.pixel_bytes);
  end

  always_comb begin
    res_d.texel_col     = mp_q.tcol;
    res_d.texel_row     = mp_q.trow;
    res_d.texel_address = mp_q.ent.base + ADDR_W'(mp_q.prod_r) + ADDR_W'(mp_q.prod_c);
    res_d.out_column    = mp_q.ent.scol;
    res_d.out_row       = mp_q.ent.srow;
    res_d.strip_last    = mp_q.ent.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clp_v_q <= 1'b0;
      mp_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      clp_v_q <= div_v_q[DIV_STEPS-1];
      mp_v_q  <= clp_v_q;
      res_v_q <= mp_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    clp_q <= clp_d;
    mp_q  <= mp_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule

### design/wall_texel_address_generator_unit.sv
// Top level of the wall texel address generator: config registers, front, queue, back.
`timescale 1ns / 1ps

// Usage
//   Input: drive the pixel fields and raise start; the item transfers on a
//   rising edge with start high and busy low. One item may follow every cycle.
//   Output: each pixel gives one result, shown for one cycle with done_o high.
//   The receiver cannot hold results off; results come out in input order.
//   Pipeline: between the accepting edge and the edge that takes the result
//   lie the front register, queue, 16 modulo steps, a multiply stage, 13
//   divider steps, clamp, address multiply and address add. The modulo and
//   divider pipelines set the depth; throughput is one pixel per cycle.
//   busy rises only if the queue is nearly full, which the free-running back
//   end never lets happen in normal use.
//   Config: write cfg_wdata_i to register cfg_idx_i (0 tile_size,
//   1 tex_width, 2 tex_height, 3 row_pitch, 4 pixel_bytes) with cfg_we_i;
//   other indexes are ignored. Write only while no pixel is in flight.
//   Reset: rst_ni low empties the pipeline and loads tile 64, texture
//   64 x 64, pitch 256, 4 bytes per texel.
module wall_texel_address_generator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [wtag_pkg::HIT_W-1:0]          hit_x_i,
  input  logic [wtag_pkg::HIT_W-1:0]          hit_y_i,
  input  logic                                vertical_hit_i,
  input  logic [wtag_pkg::SCR_W-1:0]          screen_row_i,
  input  logic signed [wtag_pkg::WTOP_W-1:0]  wall_top_i,
  input  logic [wtag_pkg::STRIP_W-1:0]        strip_height_i,
  input  logic [wtag_pkg::SCR_W-1:0]          screen_column_i,
  input  logic                                column_end_i,
  input  logic [wtag_pkg::ADDR_W-1:0]         texture_base_i,
  output logic                                done_o,
  output logic [wtag_pkg::SCR_W-1:0]          texel_col_o,
  output logic [wtag_pkg::SCR_W-1:0]          texel_row_o,
  output logic [wtag_pkg::ADDR_W-1:0]         texel_address_o,
  output logic [wtag_pkg::SCR_W-1:0]          out_column_o,
  output logic [wtag_pkg::SCR_W-1:0]          out_row_o,
  output logic                                strip_last_o,
  input  logic                                cfg_we_i,
  input  logic [wtag_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wtag_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import wtag_pkg::*;

  localparam int LATENCY = 2 + MOD_STEPS + 1 + DIV_STEPS + 3;

  cfg_t cfg_q;
  ent_t front_ent, fifo_ent;
  logic push, fifo_valid, fifo_afull, res_valid;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_size   <= TILE_W'(64);
      cfg_q.tex_width   <= TEX_W'(64);
      cfg_q.tex_height  <= TEX_W'(64);
      cfg_q.row_pitch   <= PITCH_W'(256);
      cfg_q.pixel_bytes <= PBYTES_W'(4);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TILE_SIZE:   cfg_q.tile_size   <= cfg_wdata_i[TILE_W-1:0];
        CFG_TEX_WIDTH:   cfg_q.tex_width   <= cfg_wdata_i[TEX_W-1:0];
        CFG_TEX_HEIGHT:  cfg_q.tex_height  <= cfg_wdata_i[TEX_W-1:0];
        CFG_ROW_PITCH:   cfg_q.row_pitch   <= cfg_wdata_i[PITCH_W-1:0];
        CFG_PIXEL_BYTES: cfg_q.pixel_bytes <= cfg_wdata_i[PBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  wtag_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .hold_i         (fifo_afull),
    .busy           (busy),
    .hit_x_i        (hit_x_i),
    .hit_y_i        (hit_y_i),
    .vertical_hit_i (vertical_hit_i),
    .screen_row_i   (screen_row_i),
    .wall_top_i     (wall_top_i),
    .strip_height_i (strip_height_i),
    .screen_column_i(screen_column_i),
    .column_end_i   (column_end_i),
    .texture_base_i (texture_base_i),
    .push_o         (push),
    .ent_o          (front_ent)
  );

  // the back end never stalls, so the queue head is taken whenever present
  wtag_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_ent),
    .pop_i  (fifo_valid),
    .valid_o(fifo_valid),
    .data_o (fifo_ent),
    .afull_o(fifo_afull)
  );

  wtag_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fifo_valid),
    .in_ent_i   (fifo_ent),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign done_o          = res_valid;
  assign texel_col_o     = res.texel_col;
  assign texel_row_o     = res.texel_row;
  assign texel_address_o = res.texel_address;
  assign out_column_o    = res.out_column;
  assign out_row_o       = res.out_row;
  assign strip_last_o    = res.strip_last;

  // queue drains every cycle, so it can never back up to the input
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("input stalled although back end drains every cycle");

  // every transfer produces its result after the fixed pipeline depth
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("result missing after pipeline latency");

endmodule

### sim/texel_address_checker.sv
// Checker for the wall texel address generator: tracks config, predicts texel results, compares.
`timescale 1ns / 1ps

module texel_address_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic                                busy,
  input  logic [wtag_pkg::HIT_W-1:0]          hit_x_i,
  input  logic [wtag_pkg::HIT_W-1:0]          hit_y_i,
  input  logic                                vertical_hit_i,
  input  logic [wtag_pkg::SCR_W-1:0]          screen_row_i,
  input  logic signed [wtag_pkg::WTOP_W-1:0]  wall_top_i,
  input  logic [wtag_pkg::STRIP_W-1:0]        strip_height_i,
  input  logic [wtag_pkg::SCR_W-1:0]          screen_column_i,
  input  logic                                column_end_i,
  input  logic [wtag_pkg::ADDR_W-1:0]         texture_base_i,
  input  logic                                done_o,
  input  logic [wtag_pkg::SCR_W-1:0]          texel_col_o,
  input  logic [wtag_pkg::SCR_W-1:0]          texel_row_o,
  input  logic [wtag_pkg::ADDR_W-1:0]         texel_address_o,
  input  logic [wtag_pkg::SCR_W-1:0]          out_column_o,
  input  logic [wtag_pkg::SCR_W-1:0]          out_row_o,
  input  logic                                strip_last_o,
  input  logic                                cfg_we_i,
  input  logic [wtag_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wtag_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output int                                  fail_count,
  output int                                  texels_checked,
  output int                                  texels_pending
);
  import wtag_pkg::*;

  cfg_t settings;
  res_t texel_expect_q[$];

  // limit a scaled coordinate to the texture and to the output field
  function automatic logic [SCR_W-1:0] clamp_texel(input longint unsigned v,
                                                   input logic [TEX_W-1:0] size);
    if (size == '0) return '0;
    if (v > 64'(size) - 64'd1) v = 64'(size) - 64'd1;
    if (v > 64'(FIELD_MAX)) v = 64'(FIELD_MAX);
    return v[SCR_W-1:0];
  endfunction

  function automatic res_t texel_for_pixel(
    input logic [HIT_W-1:0]         hx,
    input logic [HIT_W-1:0]         hy,
    input logic                     vert,
    input logic [SCR_W-1:0]         srow,
    input logic signed [WTOP_W-1:0] top,
    input logic [STRIP_W-1:0]       strip,
    input logic [SCR_W-1:0]         scol,
    input logic                     last,
    input logic [ADDR_W-1:0]        base
  );
    longint unsigned hit;
    longint unsigned tile_fx;
    longint unsigned quo;
    longint unsigned div;
    longint          diff;
    res_t            r;
    hit = vert ? 64'(hy) : 64'(hx);
    r.texel_col = '0;
    if (settings.tile_size != 0) begin
      tile_fx = longint'(settings.tile_size) << COORD_FRAC_BITS;
      quo = ((hit % tile_fx) * settings.tex_width) / tile_fx;
      r.texel_col = clamp_texel(quo, settings.tex_width);
    end
    r.texel_row = '0;
    diff = longint'(srow) - longint'(top);
    if (diff > 0) begin
      div = (strip == '0) ? 64'd1 : 64'(strip);
      quo = (diff * settings.tex_height) / div;
      r.texel_row = clamp_texel(quo, settings.tex_height);
    end
    r.texel_address = base + r.texel_row * settings.row_pitch
                    + r.texel_col * settings.pixel_bytes;
    r.out_column = scol;
    r.out_row    = srow;
    r.strip_last = last;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      settings.tile_size   = 64;
      settings.tex_width   = 64;
      settings.tex_height  = 64;
      settings.row_pitch   = 256;
      settings.pixel_bytes = 4;
      fail_count           = 0;
      texels_checked       = 0;
      texel_expect_q.delete();
      texels_pending <= 0;
    end else begin
      if (done_o) begin
        if (texel_expect_q.size() == 0) begin
          $error("texel result with none outstanding: col 0x%0h row 0x%0h addr 0x%0h",
                 texel_col_o, texel_row_o, texel_address_o);
          fail_count++;
        end else begin
          want = texel_expect_q.pop_front();
          check_field("texel_col", ADDR_W'(want.texel_col), ADDR_W'(texel_col_o));
          check_field("texel_row", ADDR_W'(want.texel_row), ADDR_W'(texel_row_o));
          check_field("texel_address", want.texel_address, texel_address_o);
          check_field("out_column", ADDR_W'(want.out_column), ADDR_W'(out_column_o));
          check_field("out_row", ADDR_W'(want.out_row), ADDR_W'(out_row_o));
          check_field("strip_last", ADDR_W'(want.strip_last), ADDR_W'(strip_last_o));
          texels_checked++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TILE_SIZE:   settings.tile_size   = cfg_wdata_i[TILE_W-1:0];
          CFG_TEX_WIDTH:   settings.tex_width   = cfg_wdata_i[TEX_W-1:0];
          CFG_TEX_HEIGHT:  settings.tex_height  = cfg_wdata_i[TEX_W-1:0];
          CFG_ROW_PITCH:   settings.row_pitch   = cfg_wdata_i[PITCH_W-1:0];
          CFG_PIXEL_BYTES: settings.pixel_bytes = cfg_wdata_i[PBYTES_W-1:0];
          default: ;
        endcase
      end
      // pixel transfer
      if (start && !busy) begin
        texel_expect_q.push_back(texel_for_pixel(hit_x_i, hit_y_i, vertical_hit_i,
                                                 screen_row_i, wall_top_i, strip_height_i,
                                                 screen_column_i, column_end_i,
                                                 texture_base_i));
      end
      texels_pending <= texel_expect_q.size();
    end
  end

endmodule

### sim/wall_texel_address_generator_unit_tb.sv
// Testbench top for the wall texel address generator: clock, reset, pixel and config stimulus.
`timescale 1ns / 1ps

module wall_texel_address_generator_unit_tb;
  import wtag_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef struct packed {
    logic [HIT_W-1:0]         hit_x;
    logic [HIT_W-1:0]         hit_y;
    logic                     vertical;
    logic [SCR_W-1:0]         screen_row;
    logic [WTOP_W-1:0]        wall_top;
    logic [STRIP_W-1:0]       strip;
    logic [SCR_W-1:0]         screen_col;
    logic                     col_end;
    logic [ADDR_W-1:0]        base;
  } pixel_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [HIT_W-1:0]          hit_x_i;
  logic [HIT_W-1:0]          hit_y_i;
  logic                      vertical_hit_i;
  logic [SCR_W-1:0]          screen_row_i;
  logic signed [WTOP_W-1:0]  wall_top_i;
  logic [STRIP_W-1:0]        strip_height_i;
  logic [SCR_W-1:0]          screen_column_i;
  logic                      column_end_i;
  logic [ADDR_W-1:0]         texture_base_i;
  logic                      done_o;
  logic [SCR_W-1:0]          texel_col_o;
  logic [SCR_W-1:0]          texel_row_o;
  logic [ADDR_W-1:0]         texel_address_o;
  logic [SCR_W-1:0]          out_column_o;
  logic [SCR_W-1:0]          out_row_o;
  logic                      strip_last_o;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [CFG_DATA_W-1:0]     cfg_wdata_i;

  int fail_count;
  int texels_checked;
  int texels_pending;
  int pixels_sent;
  int settings_used;

  wall_texel_address_generator_unit u_dut (.*);

  texel_address_checker u_check (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 500000);
    $display("Simulation FAILED");
    $finish;
  end

  // holds start high until the pixel transfers; leaves start high on return
  task automatic send_pixel(input pixel_t p);
    hit_x_i         <= p.hit_x;
    hit_y_i         <= p.hit_y;
    vertical_hit_i  <= p.vertical;
    screen_row_i    <= p.screen_row;
    wall_top_i      <= p.wall_top;
    strip_height_i  <= p.strip;
    screen_column_i <= p.screen_col;
    column_end_i    <= p.col_end;
    texture_base_i  <= p.base;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
    pixels_sent++;
  endtask

  task automatic send_fields(input logic [HIT_W-1:0] hx, input logic [HIT_W-1:0] hy,
                             input logic vert, input logic [SCR_W-1:0] row,
                             input logic [WTOP_W-1:0] top, input logic [STRIP_W-1:0] strip,
                             input logic [SCR_W-1:0] col, input logic last,
                             input logic [ADDR_W-1:0] base);
    pixel_t p;
    p = {hx, hy, vert, row, top, strip, col, last, base};
    send_pixel(p);
  endtask

  // mostly pixels that lie inside their wall strip, some arbitrary ones
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     top_v;
    p.hit_x      = HIT_W'($urandom_range(0, 24'hFF_FFFF));
    p.hit_y      = HIT_W'($urandom_range(0, 24'hFF_FFFF));
    p.vertical   = 1'($urandom_range(0, 1));
    p.screen_row = SCR_W'($urandom_range(0, 4095));
    p.screen_col = SCR_W'($urandom_range(0, 4095));
    p.col_end    = ($urandom_range(0, 5) == 0);
    p.base       = $urandom;
    if ($urandom_range(0, 99) < 70) begin
      p.strip = STRIP_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 65535 : 1024));
      top_v   = int'(p.screen_row) - int'($urandom_range(0, p.strip));
      if (top_v < -32768) top_v = -32768;
      p.wall_top = top_v[WTOP_W-1:0];
    end else begin
      p.strip    = STRIP_W'($urandom_range(0, 65535));
      p.wall_top = WTOP_W'($urandom_range(0, 65535));
    end
    return p;
  endfunction

  task automatic run_pixels(input int count, input int idle_pct);
    repeat (count) begin
      send_pixel(random_pixel());
      if ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 45) : $urandom_range(1, 3))
          @(posedge clk_i);
      end
    end
    start <= 1'b0;
  endtask

  // the pending count is a registered copy of the checker queue size, so it lags the queue
  task automatic wait_drained();
    @(posedge clk_i);
    while (texels_pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [CFG_DATA_W-1:0] tile, input logic [CFG_DATA_W-1:0] tw,
                                input logic [CFG_DATA_W-1:0] th,
                                input logic [CFG_DATA_W-1:0] pitch,
                                input logic [CFG_DATA_W-1:0] pb);
    put_reg(CFG_TILE_SIZE, tile);
    put_reg(CFG_TEX_WIDTH, tw);
    put_reg(CFG_TEX_HEIGHT, th);
    put_reg(CFG_ROW_PITCH, pitch);
    put_reg(CFG_PIXEL_BYTES, pb);
    // unmapped index must leave every register alone
    put_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int idle_by_phase[4];
    idle_by_phase = '{0, 47, 0, 22};
    pixels_sent     = 0;
    settings_used   = 1;
    rst_ni          = 1'b0;
    start           = 1'b0;
    hit_x_i         = '0;
    hit_y_i         = '0;
    vertical_hit_i  = 1'b0;
    screen_row_i    = '0;
    wall_top_i      = '0;
    strip_height_i  = '0;
    screen_column_i = '0;
    column_end_i    = 1'b0;
    texture_base_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_TILE_SIZE;
    cfg_wdata_i     = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed pixels under the reset configuration
    send_fields('0, '0, 1'b0, '0, '0, '0, '0, 1'b0, '0);
    send_fields(24'hFF_FFFF, '0, 1'b0, 12'd4095, 16'h8000, 16'd1, 12'd4095, 1'b1,
                32'hFFFF_FFFF);
    send_fields('0, 24'hFF_FFFF, 1'b1, 12'd4095, 16'h7FFF, 16'hFFFF, '0, 1'b0, '0);
    send_fields(24'h00_3FFF, '0, 1'b0, 12'd100, 16'd100, 16'd50, 12'd7, 1'b0, 32'd1000);
    send_fields(24'h00_4000, '0, 1'b0, 12'd100, 16'd101, 16'd50, 12'd8, 1'b1, 32'd2000);
    send_fields(24'h00_2080, 24'h12_3456, 1'b0, 12'd150, 16'd100, 16'd100, 12'd9, 1'b0,
                32'h8000_0000);
    // zero strip height acts as one
    send_fields(24'h12_3456, 24'h00_00FF, 1'b1, 12'd200, '0, '0, 12'd10, 1'b0, 32'h1234_5678);
    send_fields(24'h00_3FFF, 24'h00_3FFF, 1'b1, 12'd4095, 16'h8000, 16'hFFFF, 12'd11, 1'b1,
                32'h0000_0100);
    send_fields('0, '0, 1'b0, 12'd1, '0, 16'd1, 12'd12, 1'b0, 32'hFFFF_FFF0);
    send_fields(24'h00_4001, 24'hFF_C000, 1'b0, 12'd33, 16'hFFE0, 16'd64, 12'd13, 1'b0,
                32'h0F0F_0F0F);
    send_fields(24'hFF_FFFF, 24'hFF_FFFF, 1'b1, 12'd64, '0, 16'd64, 12'd2048, 1'b1,
                32'hFFFF_FF00);
    send_fields(24'hFF_FFFF, '0, 1'b1, 12'd63, 16'd62, 16'd3, 12'd1, 1'b0, 32'hAAAA_5555);
    start <= 1'b0;
    run_pixels(150, 22);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: write_settings(16'h07FF, 16'h1FFF, 16'h1FFF, 16'hFFFF, 16'h000F);
        1: write_settings('0, '0, '0, '0, '0);
        2: write_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        3: write_settings(16'd1024, '0, 16'd4096, 16'hFFFF, 16'd8);
        4: write_settings('0, 16'd4096, '0, 16'd1, 16'd1);
        default: begin
          if ($urandom_range(0, 3) == 0)
            write_settings(CFG_DATA_W'($urandom_range(0, 65535)),
                           CFG_DATA_W'($urandom_range(0, 65535)),
                           CFG_DATA_W'($urandom_range(0, 65535)),
                           CFG_DATA_W'($urandom_range(0, 65535)),
                           CFG_DATA_W'($urandom_range(0, 65535)));
          else
            write_settings(CFG_DATA_W'($urandom_range(1, 1024)),
                           CFG_DATA_W'($urandom_range(1, 4096)),
                           CFG_DATA_W'($urandom_range(1, 4096)),
                           CFG_DATA_W'($urandom_range(1, 65535)),
                           CFG_DATA_W'($urandom_range(1, 8)));
        end
      endcase
      run_pixels(175, idle_by_phase[ph % 4]);
    end

    wait_drained();
    repeat (45) @(posedge clk_i);
    $display("Sent %0d pixels over %0d register settings (zero, minimum, maximum, random);",
             pixels_sent, settings_used);
    $display("checked %0d texel results with idle gaps of 0 to 45 cycles.", texels_checked);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
